>>> rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants of the single-wire sensor reader
// Holds the register map, the read sequence phases and the structs that
// carry configuration and one per-tick result between the modules.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int MaxLines   = 8;
  localparam int ChanW      = $clog2(MaxLines);
  localparam int FrameBits  = 40;
  localparam int BitsW      = 6;
  localparam int TimerW     = 20;
  localparam int PaddrW     = 5;
  localparam int PdataW     = 32;

  // Register reset values.
  localparam logic [19:0] IdleHighRst    = 20'd300000;
  localparam logic [15:0] StartLowRst    = 16'd18000;
  localparam logic [7:0]  ReleaseHighRst = 8'd20;
  localparam logic [7:0]  RespFirstRst   = 8'd40;
  localparam logic [7:0]  RespSecondRst  = 8'd80;
  localparam logic [7:0]  BitSampleRst   = 8'd40;
  localparam logic [15:0] WaitLimitRst   = 16'd1000;
  localparam logic [3:0]  ChanCountRst   = 4'd5;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_IDLE_HIGH    = 3'd0,
    REG_START_LOW    = 3'd1,
    REG_RELEASE_HIGH = 3'd2,
    REG_RESP_FIRST   = 3'd3,
    REG_RESP_SECOND  = 3'd4,
    REG_BIT_SAMPLE   = 3'd5,
    REG_WAIT_LIMIT   = 3'd6,
    REG_CHAN_COUNT   = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_HOLD_HIGH     = 4'd1,
    PH_START_LOW     = 4'd2,
    PH_RELEASE_HIGH  = 4'd3,
    PH_RESP_FIRST    = 4'd4,
    PH_RESP_SECOND   = 4'd5,
    PH_RESP_WAIT_LOW = 4'd6,
    PH_BIT_WAIT_RISE = 4'd7,
    PH_BIT_DELAY     = 4'd8,
    PH_BIT_WAIT_FALL = 4'd9
  } phase_e;

  typedef struct packed {
    logic [19:0] idle_high;
    logic [15:0] start_low;
    logic [7:0]  release_high;
    logic [7:0]  resp_first;
    logic [7:0]  resp_second;
    logic [7:0]  bit_sample;
    logic [15:0] wait_limit;
    logic [3:0]  chan_count;
  } cfg_t;

  typedef struct packed {
    logic             drive_enable;
    logic             drive_level;
    logic [ChanW-1:0] active_line;
    logic             reading_valid;
    logic             sensor_present;
    logic [7:0]       humidity;
    logic [7:0]       temperature;
  } res_t;

endpackage

>>> rtl/msr_cfg.sv
// ----------------------------------------------------------------------------
// msr_cfg: configuration register file
// APB-style slave holding the timing registers and the channel count.
// ----------------------------------------------------------------------------
module msr_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msr_pkg::PaddrW-1:0] paddr,
  input  logic [msr_pkg::PdataW-1:0] pwdata,
  output logic [msr_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output msr_pkg::cfg_t              cfg_o
);
  import msr_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[PaddrW-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_high    <= IdleHighRst;
      cfg_q.start_low    <= StartLowRst;
      cfg_q.release_high <= ReleaseHighRst;
      cfg_q.resp_first   <= RespFirstRst;
      cfg_q.resp_second  <= RespSecondRst;
      cfg_q.bit_sample   <= BitSampleRst;
      cfg_q.wait_limit   <= WaitLimitRst;
      cfg_q.chan_count   <= ChanCountRst;
    end else if (wr_en) begin
      case (reg_sel)
        REG_IDLE_HIGH:    cfg_q.idle_high    <= pwdata[19:0];
        REG_START_LOW:    cfg_q.start_low    <= pwdata[15:0];
        REG_RELEASE_HIGH: cfg_q.release_high <= pwdata[7:0];
        REG_RESP_FIRST:   cfg_q.resp_first   <= pwdata[7:0];
        REG_RESP_SECOND:  cfg_q.resp_second  <= pwdata[7:0];
        REG_BIT_SAMPLE:   cfg_q.bit_sample   <= pwdata[7:0];
        REG_WAIT_LIMIT:   cfg_q.wait_limit   <= pwdata[15:0];
        REG_CHAN_COUNT:   cfg_q.chan_count   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IDLE_HIGH:    prdata = {12'd0, cfg_q.idle_high};
      REG_START_LOW:    prdata = {16'd0, cfg_q.start_low};
      REG_RELEASE_HIGH: prdata = {24'd0, cfg_q.release_high};
      REG_RESP_FIRST:   prdata = {24'd0, cfg_q.resp_first};
      REG_RESP_SECOND:  prdata = {24'd0, cfg_q.resp_second};
      REG_BIT_SAMPLE:   prdata = {24'd0, cfg_q.bit_sample};
      REG_WAIT_LIMIT:   prdata = {16'd0, cfg_q.wait_limit};
      REG_CHAN_COUNT:   prdata = {28'd0, cfg_q.chan_count};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/msr_core.sv
// ----------------------------------------------------------------------------
// msr_core: read sequencer
// Advances the per-tick read sequence on each accepted request and forms
// the result of that tick. Keeps the last reading of every channel.
// ----------------------------------------------------------------------------
module msr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           line_levels_i,
  input  logic                 poll_tick_i,
  input  msr_pkg::cfg_t        cfg_i,
  output msr_pkg::res_t        res_o
);
  import msr_pkg::*;

  localparam logic [ChanW-1:0] ChanRst = ChanW'(ChanCountRst - 4'd1);

  phase_e            phase_q, phase_d;
  logic [TimerW-1:0] tmr_q, tmr_d;
  logic [ChanW-1:0]  chan_q, chan_d;
  logic [BitsW-1:0]  bits_q, bits_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [15:0]       store_q [MaxLines];

  logic              line;
  logic [TimerW:0]   tmr_inc;
  logic [TimerW-1:0] limit;
  logic              limit_hit;
  logic [3:0]        eff_count;
  logic [3:0]        next_chan;
  logic              finish, ok;
  logic [15:0]       reading;

  assign line    = line_levels_i[chan_q];
  assign tmr_inc = {1'b0, tmr_q} + 21'd1;

  // Zero channels behave as one, more than the line count as all lines.
  always_comb begin
    if (cfg_i.chan_count == 4'd0) begin
      eff_count = 4'd1;
    end else if (cfg_i.chan_count > 4'(MaxLines)) begin
      eff_count = 4'(MaxLines);
    end else begin
      eff_count = cfg_i.chan_count;
    end
    next_chan = {1'b0, chan_q} + 4'd1;
    if (next_chan >= eff_count) begin
      next_chan = 4'd0;
    end
  end

  // One shared compare serves every timed phase and every edge wait.
  always_comb begin
    case (phase_q)
      PH_HOLD_HIGH:     limit = cfg_i.idle_high;
      PH_START_LOW:     limit = {4'd0, cfg_i.start_low};
      PH_RELEASE_HIGH:  limit = {12'd0, cfg_i.release_high};
      PH_RESP_FIRST:    limit = {12'd0, cfg_i.resp_first};
      PH_RESP_SECOND:   limit = {12'd0, cfg_i.resp_second};
      PH_BIT_DELAY:     limit = {12'd0, cfg_i.bit_sample};
      default:          limit = {4'd0, cfg_i.wait_limit};
    endcase
    limit_hit = tmr_inc >= {1'b0, limit};
  end

  always_comb begin
    phase_d = phase_q;
    tmr_d   = tmr_q;
    chan_d  = chan_q;
    bits_d  = bits_q;
    frame_d = frame_q;
    finish  = 1'b0;
    ok      = 1'b0;
    res_o.drive_enable = 1'b0;
    res_o.drive_level  = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (poll_tick_i) begin
          chan_d  = next_chan[ChanW-1:0];
          bits_d  = '0;
          frame_d = '0;
          phase_d = PH_HOLD_HIGH;
          tmr_d   = '0;
        end
      end
      PH_HOLD_HIGH, PH_START_LOW, PH_RELEASE_HIGH: begin
        res_o.drive_enable = 1'b1;
        res_o.drive_level  = (phase_q != PH_START_LOW);
        tmr_d = limit_hit ? '0 : tmr_inc[TimerW-1:0];
        if (limit_hit) begin
          case (phase_q)
            PH_HOLD_HIGH: phase_d = PH_START_LOW;
            PH_START_LOW: phase_d = PH_RELEASE_HIGH;
            default:      phase_d = PH_RESP_FIRST;
          endcase
        end
      end
      PH_RESP_FIRST: begin
        tmr_d = limit_hit ? '0 : tmr_inc[TimerW-1:0];
        if (limit_hit) begin
          if (!line) phase_d = PH_RESP_SECOND;
          else       finish  = 1'b1;
        end
      end
      PH_RESP_SECOND: begin
        tmr_d = limit_hit ? '0 : tmr_inc[TimerW-1:0];
        if (limit_hit) begin
          if (line) phase_d = PH_RESP_WAIT_LOW;
          else      finish  = 1'b1;
        end
      end
      PH_RESP_WAIT_LOW: begin
        if (!line) begin
          phase_d = PH_BIT_WAIT_RISE;
          tmr_d   = '0;
        end else begin
          tmr_d  = limit_hit ? '0 : tmr_inc[TimerW-1:0];
          finish = limit_hit;
        end
      end
      PH_BIT_WAIT_RISE: begin
        if (line) begin
          phase_d = PH_BIT_DELAY;
          tmr_d   = '0;
        end else begin
          tmr_d  = limit_hit ? '0 : tmr_inc[TimerW-1:0];
          finish = limit_hit;
        end
      end
      PH_BIT_DELAY: begin
        tmr_d = limit_hit ? '0 : tmr_inc[TimerW-1:0];
        if (limit_hit) begin
          frame_d = {frame_q[FrameBits-2:0], line};
          bits_d  = bits_q + 6'd1;
          phase_d = PH_BIT_WAIT_FALL;
        end
      end
      PH_BIT_WAIT_FALL: begin
        if (!line) begin
          tmr_d = '0;
          if (bits_q >= BitsW'(FrameBits)) begin
            finish = 1'b1;
            ok     = 1'b1;
          end else begin
            phase_d = PH_BIT_WAIT_RISE;
          end
        end else begin
          tmr_d  = limit_hit ? '0 : tmr_inc[TimerW-1:0];
          finish = limit_hit;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tmr_d   = '0;
      end
    endcase

    if (finish) begin
      phase_d = PH_IDLE;
      tmr_d   = '0;
    end

    // Humidity is the first frame byte, temperature the third.
    reading = ok ? {frame_q[39:32], frame_q[23:16]} : 16'd0;

    res_o.active_line    = chan_d;
    res_o.reading_valid  = finish;
    res_o.sensor_present = ok;
    res_o.humidity       = finish ? reading[15:8] : store_q[chan_d][15:8];
    res_o.temperature    = finish ? reading[7:0]  : store_q[chan_d][7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tmr_q   <= '0;
      chan_q  <= ChanRst;
      bits_q  <= '0;
      frame_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tmr_q   <= tmr_d;
      chan_q  <= chan_d;
      bits_q  <= bits_d;
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLines; i++) begin
        store_q[i] <= '0;
      end
    end else if (accept_i && finish) begin
      store_q[chan_d] <= reading;
    end
  end

endmodule

>>> rtl/multi_channel_single_wire_sensor_reader.sv
// ----------------------------------------------------------------------------
// multi_channel_single_wire_sensor_reader: round-robin single-wire sensor reader
// Output: a result is registered in the output register when its request is accepted.
// Throughput: one request per cycle; the input stalls only while a held result
// is stalled downstream, since the output register is the only buffer.
// Reset: asynchronous, active low; sequence idle, all readings zero, the
// channel pointer at the last default channel so the first poll selects 0.
// ----------------------------------------------------------------------------
module multi_channel_single_wire_sensor_reader (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  // Tick request channel: one request per microsecond of line samples.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 line_levels_i,
  input  logic                       poll_tick_i,

  // Result channel: one result per request.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       drive_enable_o,
  output logic                       drive_level_o,
  output logic [2:0]                 active_line_o,
  output logic                       reading_valid_o,
  output logic                       sensor_present_o,
  output logic [7:0]                 humidity_o,
  output logic [7:0]                 temperature_o,

  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msr_pkg::PaddrW-1:0] paddr,
  input  logic [msr_pkg::PdataW-1:0] pwdata,
  output logic [msr_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import msr_pkg::*;

  cfg_t cfg;
  res_t res_d, res_q;
  logic out_valid_q;
  logic accept;

  // A request is taken whenever the output register is empty or is being
  // emptied in the same cycle, so the sequencer keeps pace with the ticks.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  msr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The sequencer state only advances on an accepted request, so stalls
  // never skip or repeat a microsecond of the read sequence.
  msr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .line_levels_i (line_levels_i),
    .poll_tick_i   (poll_tick_i),
    .cfg_i         (cfg),
    .res_o         (res_d)
  );

  // Output register: loaded on acceptance, held while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_enable_o   = res_q.drive_enable;
  assign drive_level_o    = res_q.drive_level;
  assign active_line_o    = res_q.active_line;
  assign reading_valid_o  = res_q.reading_valid;
  assign sensor_present_o = res_q.sensor_present;
  assign humidity_o       = res_q.humidity;
  assign temperature_o    = res_q.temperature;

  // A read only finishes in a phase where the line is released.
  a_finish_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reading_valid_o |-> !drive_enable_o)
    else $error("reading finished while the line was driven");

  // An absent sensor reports zero readings.
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reading_valid_o && !sensor_present_o |->
      humidity_o == 8'd0 && temperature_o == 8'd0)
    else $error("absent sensor reported a nonzero reading");

  // Presence is only reported together with a finished read.
  a_present_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_present_o |-> reading_valid_o)
    else $error("sensor presence reported outside a finished read");

  // A high level is only shown while the line is actually driven.
  a_level_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_level_o |-> drive_enable_o)
    else $error("drive level set while the line was released");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the multi-channel single-wire sensor reader
// Drives one request per microsecond tick, shaping the active line like a real
// sensor would answer (presence pulse, 40 data bits, now and then a sensor
// that stops answering), predicts every per-tick result and compares it field
// by field as the result leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import msr_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        line_levels_i = 8'h00;
  logic              poll_tick_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              drive_enable_o;
  logic              drive_level_o;
  logic [2:0]        active_line_o;
  logic              reading_valid_o;
  logic              sensor_present_o;
  logic [7:0]        humidity_o;
  logic [7:0]        temperature_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  multi_channel_single_wire_sensor_reader i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .line_levels_i    (line_levels_i),
    .poll_tick_i      (poll_tick_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_enable_o   (drive_enable_o),
    .drive_level_o    (drive_level_o),
    .active_line_o    (active_line_o),
    .reading_valid_o  (reading_valid_o),
    .sensor_present_o (sensor_present_o),
    .humidity_o       (humidity_o),
    .temperature_o    (temperature_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // --------------------------------------------------------------------------
  // Bookkeeping shared by the sender, the receiver and the checker.
  // --------------------------------------------------------------------------
  res_t tick_out_q[$];      // predicted results of accepted requests, oldest first
  int   mismatches = 0;
  int   requests_sent = 0;
  int   readings_done = 0;
  int   readings_present = 0;
  int   settings_loaded = 0;

  int   gap_pct = 0;        // chance in percent that the sender idles a cycle
  int   stall_pct = 0;      // chance in percent that the receiver stalls a cycle
  int   holdoffs_asked = 0;
  int   holdoffs_served = 0;
  int   holdoff_left = 0;

  // Sensor emulation: the data bit at which the sensor stops answering (-1 if
  // it answers the whole frame), and a value that overrides the random choice.
  int   stuck_bit = -1;
  int   forced_stuck = -1;

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the configuration and of the sequencer.
  // --------------------------------------------------------------------------
  cfg_t              cfg_shadow = '{IdleHighRst, StartLowRst, ReleaseHighRst, RespFirstRst,
                                    RespSecondRst, BitSampleRst, WaitLimitRst, ChanCountRst};
  phase_e            pr_phase = PH_IDLE;
  int unsigned       pr_timer = 0;
  logic [ChanW-1:0]  pr_chan = ChanW'(ChanCountRst - 1);
  logic [BitsW-1:0]  pr_bits = '0;
  logic [39:0]       pr_frame = '0;
  logic [15:0]       pr_store [MaxLines] = '{default: 16'h0000};

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    sel;
    logic [31:0] value;
    logic [7:0]  lines;
    logic        poll;
    bit          fixed;
    res_t        want;
  } dir_row_t;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Channel count 0 behaves as one line, anything above the line count as all.
  function automatic int unsigned lines_in_use();
    int unsigned n;
    n = cfg_shadow.chan_count;
    if (n == 0) n = 1;
    if (n > MaxLines) n = MaxLines;
    return n;
  endfunction

  function automatic void go_phase(input phase_e p);
    pr_phase = p;
    pr_timer = 0;
  endfunction

  // A timed phase of length d lasts max(d,1) ticks; true on its last tick.
  function automatic bit timed_done(input int unsigned d);
    int unsigned c;
    c = pr_timer + 1;
    if (c >= d) begin
      pr_timer = 0;
      return 1'b1;
    end
    pr_timer = c;
    return 1'b0;
  endfunction

  // An edge wait gives up once wait_limit ticks have passed without the edge.
  function automatic bit edge_expired();
    int unsigned c;
    c = pr_timer + 1;
    if (c >= cfg_shadow.wait_limit) begin
      pr_timer = 0;
      return 1'b1;
    end
    pr_timer = c;
    return 1'b0;
  endfunction

  // Advances the predicted sequencer by one tick and returns the result that
  // the block should report for it.
  task automatic sensor_reader_tick(input logic [7:0] lv, input logic pl, output res_t r);
    logic        line;
    bit          done;
    bit          good;
    int unsigned nx;
    logic [15:0] rec;
    line = lv[pr_chan];
    done = 1'b0;
    good = 1'b0;
    r = '0;
    case (pr_phase)
      PH_IDLE: begin
        // Polls are honored only here; a poll during a read is dropped.
        if (pl) begin
          nx = pr_chan + 1;
          if (nx >= lines_in_use()) nx = 0;
          pr_chan = nx[ChanW-1:0];
          pr_bits = '0;
          pr_frame = '0;
          go_phase(PH_HOLD_HIGH);
        end
      end
      PH_HOLD_HIGH: begin
        r.drive_enable = 1'b1;
        r.drive_level = 1'b1;
        if (timed_done(cfg_shadow.idle_high)) go_phase(PH_START_LOW);
      end
      PH_START_LOW: begin
        r.drive_enable = 1'b1;
        if (timed_done(cfg_shadow.start_low)) go_phase(PH_RELEASE_HIGH);
      end
      PH_RELEASE_HIGH: begin
        r.drive_enable = 1'b1;
        r.drive_level = 1'b1;
        if (timed_done(cfg_shadow.release_high)) go_phase(PH_RESP_FIRST);
      end
      PH_RESP_FIRST: begin
        if (timed_done(cfg_shadow.resp_first)) begin
          if (!line) go_phase(PH_RESP_SECOND);
          else done = 1'b1;
        end
      end
      PH_RESP_SECOND: begin
        if (timed_done(cfg_shadow.resp_second)) begin
          if (line) go_phase(PH_RESP_WAIT_LOW);
          else done = 1'b1;
        end
      end
      PH_RESP_WAIT_LOW: begin
        if (!line) go_phase(PH_BIT_WAIT_RISE);
        else if (edge_expired()) done = 1'b1;
      end
      PH_BIT_WAIT_RISE: begin
        if (line) go_phase(PH_BIT_DELAY);
        else if (edge_expired()) done = 1'b1;
      end
      PH_BIT_DELAY: begin
        if (timed_done(cfg_shadow.bit_sample)) begin
          pr_frame = {pr_frame[38:0], line};
          pr_bits = pr_bits + 1'b1;
          go_phase(PH_BIT_WAIT_FALL);
        end
      end
      PH_BIT_WAIT_FALL: begin
        if (!line) begin
          if (pr_bits >= FrameBits) begin
            done = 1'b1;
            good = 1'b1;
          end else begin
            go_phase(PH_BIT_WAIT_RISE);
          end
        end else if (edge_expired()) begin
          done = 1'b1;
        end
      end
      default: go_phase(PH_IDLE);
    endcase
    if (done) begin
      // Humidity is the first frame byte, temperature the third; an absent
      // sensor leaves zeros behind.
      rec = good ? {pr_frame[39:32], pr_frame[23:16]} : 16'h0000;
      pr_store[pr_chan] = rec;
      r.reading_valid = 1'b1;
      r.sensor_present = good;
      go_phase(PH_IDLE);
    end
    r.active_line = pr_chan;
    r.humidity = pr_store[pr_chan][15:8];
    r.temperature = pr_store[pr_chan][7:0];
  endtask

  // --------------------------------------------------------------------------
  // Request side. The payload is set at the falling edge and held until the
  // rising edge at which the block takes it; only then is the predictor run.
  // --------------------------------------------------------------------------
  task automatic offer_tick(input logic [7:0] lv, input logic pl, input bit fixed,
                            input res_t want);
    res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    line_levels_i = lv;
    poll_tick_i = pl;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sensor_reader_tick(lv, pl, predicted);
    tick_out_q.push_back(fixed ? want : predicted);
    requests_sent++;
  endtask

  // Lets every pending result come out, then lets the
  // output register settle, so that the block is idle for a register write.
  task automatic drain_results();
    int w;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    for (w = 0; w < 50000 && tick_out_q.size() != 0; w++) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_access(input cfg_reg_e r, input bit wr, input logic [31:0] v,
                            output logic [31:0] rd);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Writes one register, mirrors it in the shadow copy and reads it back.
  task automatic write_reg(input cfg_reg_e r, input logic [31:0] v);
    logic [31:0] mask;
    logic [31:0] rd;
    case (r)
      REG_IDLE_HIGH: begin
        mask = 32'h000F_FFFF;
        cfg_shadow.idle_high = v[19:0];
      end
      REG_START_LOW: begin
        mask = 32'h0000_FFFF;
        cfg_shadow.start_low = v[15:0];
      end
      REG_RELEASE_HIGH: begin
        mask = 32'h0000_00FF;
        cfg_shadow.release_high = v[7:0];
      end
      REG_RESP_FIRST: begin
        mask = 32'h0000_00FF;
        cfg_shadow.resp_first = v[7:0];
      end
      REG_RESP_SECOND: begin
        mask = 32'h0000_00FF;
        cfg_shadow.resp_second = v[7:0];
      end
      REG_BIT_SAMPLE: begin
        mask = 32'h0000_00FF;
        cfg_shadow.bit_sample = v[7:0];
      end
      REG_WAIT_LIMIT: begin
        mask = 32'h0000_FFFF;
        cfg_shadow.wait_limit = v[15:0];
      end
      default: begin
        mask = 32'h0000_000F;
        cfg_shadow.chan_count = v[3:0];
      end
    endcase
    apb_access(r, 1'b1, v & mask, rd);
    apb_access(r, 1'b0, '0, rd);
    if (rd !== (v & mask)) report_mismatch($sformatf("readback of %s", r.name()), rd, v & mask);
  endtask

  task automatic load_config(input cfg_t c);
    drain_results();
    write_reg(REG_IDLE_HIGH, c.idle_high);
    write_reg(REG_START_LOW, c.start_low);
    write_reg(REG_RELEASE_HIGH, c.release_high);
    write_reg(REG_RESP_FIRST, c.resp_first);
    write_reg(REG_RESP_SECOND, c.resp_second);
    write_reg(REG_BIT_SAMPLE, c.bit_sample);
    write_reg(REG_WAIT_LIMIT, c.wait_limit);
    write_reg(REG_CHAN_COUNT, c.chan_count);
    settings_loaded++;
  endtask

  // Level the sensor shows while the block waits for it: the awaited level
  // half the time, always on the last tick before the wait would expire, and
  // never once the sensor has gone quiet at this bit.
  function automatic logic edge_level(input logic awaited);
    if (int'(pr_bits) == stuck_bit) return !awaited;
    if (pr_timer + 1 >= cfg_shadow.wait_limit || $urandom_range(1) == 1) return awaited;
    return !awaited;
  endfunction

  // Builds the next tick from what the predictor says the block is doing,
  // so that most reads get through the presence check and the whole frame.
  task automatic make_sensor_tick(input bit may_poll, input bit force_poll,
                                  output logic [7:0] lv, output logic pl);
    logic bitv;
    lv = 8'($urandom());
    if (pr_phase == PH_IDLE) begin
      pl = force_poll || (may_poll && $urandom_range(99) < 40);
      if (pl) begin
        if (forced_stuck >= 0) stuck_bit = forced_stuck;
        else if ($urandom_range(6) == 0) stuck_bit = $urandom_range(FrameBits);
        else stuck_bit = -1;
      end
    end else begin
      pl = may_poll && ($urandom_range(99) < 5);
    end
    // One tick in ten keeps the fully random levels as line noise.
    if ($urandom_range(9) != 0) begin
      case (pr_phase)
        PH_RESP_FIRST:    bitv = ($urandom_range(99) < 6);
        PH_RESP_SECOND:   bitv = !($urandom_range(99) < 6);
        PH_RESP_WAIT_LOW: bitv = edge_level(1'b0);
        PH_BIT_WAIT_FALL: bitv = edge_level(1'b0);
        PH_BIT_WAIT_RISE: bitv = edge_level(1'b1);
        default:          bitv = 1'($urandom_range(1));
      endcase
      lv[pr_chan] = bitv;
    end
  endtask

  // One random phase: a poll to start, about n ticks, then ticks without
  // polls until the read in progress has finished.
  task automatic run_random(input int n, input bit squeeze);
    int         k;
    logic [7:0] lv;
    logic       pl;
    for (k = 0; k < n || pr_phase != PH_IDLE; k++) begin
      if (squeeze && k == n / 2) holdoffs_asked++;
      make_sensor_tick(k < n, k == 0, lv, pl);
      offer_tick(lv, pl, 1'b0, '0);
    end
  endtask

  function automatic dir_row_t tick_row(input logic [7:0] lv, input logic pl);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.sel = REG_IDLE_HIGH;
    d.value = '0;
    d.lines = lv;
    d.poll = pl;
    d.fixed = 1'b0;
    d.want = '0;
    return d;
  endfunction

  // Rows whose result is plain: nothing driven, zero readings, a given line and finish flag.
  function automatic dir_row_t fixed_row(input logic [7:0] lv, input logic pl,
                                         input logic [2:0] ch, input logic finished);
    dir_row_t d;
    d = tick_row(lv, pl);
    d.fixed = 1'b1;
    d.want.active_line = ch;
    d.want.reading_valid = finished;
    return d;
  endfunction

  function automatic dir_row_t reg_row(input cfg_reg_e sel, input logic [31:0] value);
    dir_row_t d;
    d = tick_row(8'h00, 1'b0);
    d.is_cfg = 1'b1;
    d.sel = sel;
    d.value = value;
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Result side. The stall is chosen at the falling edge; a long hold-off,
  // when asked for, is counted here so the block fills up and stalls its input.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i = 1'b1;
      holdoff_left--;
    end else if (holdoffs_served != holdoffs_asked) begin
      holdoffs_served++;
      holdoff_left = 60;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_result(input res_t want);
    if (drive_enable_o !== want.drive_enable)
      report_mismatch("drive_enable", drive_enable_o, want.drive_enable);
    if (drive_level_o !== want.drive_level)
      report_mismatch("drive_level", drive_level_o, want.drive_level);
    if (active_line_o !== want.active_line)
      report_mismatch("active_line", active_line_o, want.active_line);
    if (reading_valid_o !== want.reading_valid)
      report_mismatch("reading_valid", reading_valid_o, want.reading_valid);
    if (sensor_present_o !== want.sensor_present)
      report_mismatch("sensor_present", sensor_present_o, want.sensor_present);
    if (humidity_o !== want.humidity)
      report_mismatch("humidity", humidity_o, want.humidity);
    if (temperature_o !== want.temperature)
      report_mismatch("temperature", temperature_o, want.temperature);
    if (want.reading_valid) readings_done++;
    if (want.sensor_present) readings_present++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (tick_out_q.size() == 0) report_mismatch("result with no pending request", 0, 0);
      else check_result(tick_out_q.pop_front());
    end
  end

  // A correct run ends long before this timeout.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t   rows[$];
    dir_row_t   row;
    int         k;
    int         s;
    cfg_t       rnd;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with one-tick timed phases and a two-tick edge limit. All
    // eight lines are enabled before the first poll, so it lands on line 5.
    load_config('{20'd1, 16'd1, 8'd1, 8'd1, 8'd1, 8'd1, 16'd2, 4'd8});
    rows.push_back(fixed_row(8'h00, 1'b0, 3'd4, 1'b0));   // idle right after reset
    rows.push_back(fixed_row(8'hFF, 1'b1, 3'd5, 1'b0));   // first poll
    rows.push_back(tick_row(8'h00, 1'b0));                // hold high
    rows.push_back(tick_row(8'hFF, 1'b0));                // start pulse
    rows.push_back(tick_row(8'h00, 1'b0));                // release
    // First presence sample high: absent, only bit 5 set.
    rows.push_back(fixed_row(8'h20, 1'b0, 3'd5, 1'b1));
    rows.push_back(fixed_row(8'h00, 1'b1, 3'd6, 1'b0));
    rows.push_back(tick_row(8'hFF, 1'b1));                // poll during a read is dropped
    rows.push_back(tick_row(8'h00, 1'b0));
    rows.push_back(tick_row(8'hFF, 1'b0));
    rows.push_back(tick_row(8'hBF, 1'b0));                // first presence sample low
    // Second presence sample low: absent.
    rows.push_back(fixed_row(8'hBF, 1'b0, 3'd6, 1'b1));
    rows.push_back(fixed_row(8'h00, 1'b1, 3'd7, 1'b0));
    rows.push_back(tick_row(8'h00, 1'b0));
    rows.push_back(tick_row(8'h00, 1'b0));
    rows.push_back(tick_row(8'h00, 1'b0));
    rows.push_back(tick_row(8'h7F, 1'b0));
    rows.push_back(tick_row(8'h80, 1'b0));
    rows.push_back(tick_row(8'hFF, 1'b0));                // line never falls
    // Edge wait timeout: absent.
    rows.push_back(fixed_row(8'hFF, 1'b0, 3'd7, 1'b1));
    // Lowering the count below the current line makes the next poll wrap.
    rows.push_back(reg_row(REG_CHAN_COUNT, 32'd2));
    rows.push_back(fixed_row(8'hFE, 1'b1, 3'd0, 1'b0));
    rows.push_back(tick_row(8'h00, 1'b0));
    rows.push_back(tick_row(8'hFF, 1'b0));
    rows.push_back(tick_row(8'h00, 1'b0));
    rows.push_back(fixed_row(8'h01, 1'b0, 3'd0, 1'b1));

    foreach (rows[i]) begin
      row = rows[i];
      if (row.is_cfg) begin
        drain_results();
        write_reg(row.sel, row.value);
      end else begin
        offer_tick(row.lines, row.poll, row.fixed, row.want);
      end
    end

    // Every timing register at its top value; a poll would hold the line high for a
    // second, so only idle ticks run under this setting.
    load_config('{20'hF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 4'd8});
    for (k = 0; k < 12; k++) offer_tick(8'($urandom()), 1'b0, 1'b0, '0);

    // Fast timing, no idling, and one long receiver hold-off halfway through.
    load_config('{20'd1, 16'd2, 8'd1, 8'd1, 8'd1, 8'd1, 16'd3, 4'd8});
    run_random(40, 1'b1);

    // All delays and the edge limit at zero, count zero (one line); the
    // sender idles most of the time.
    gap_pct = 75;
    load_config('{20'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 4'd0});
    run_random(30, 1'b0);

    // Count above the line total; the receiver stalls most of the time.
    gap_pct = 0;
    stall_pct = 75;
    load_config('{20'd2, 16'd3, 8'd2, 8'd3, 8'd2, 8'd2, 16'd6, 4'd15});
    run_random(40, 1'b0);

    // Three lines, so a pointer left on a higher line wraps at the next poll; light idling.
    gap_pct = 8;
    stall_pct = 8;
    load_config('{20'd1, 16'd1, 8'd0, 8'd2, 8'd1, 8'd3, 16'd5, 4'd3});
    run_random(40, 1'b0);

    // Two random short settings, one with each side slow.
    for (s = 0; s < 2; s++) begin
      gap_pct = (s == 0) ? 0 : 75;
      stall_pct = (s == 0) ? 75 : 0;
      rnd.idle_high = 20'($urandom_range(4));
      rnd.start_low = 16'($urandom_range(5));
      rnd.release_high = 8'($urandom_range(3));
      rnd.resp_first = 8'($urandom_range(4));
      rnd.resp_second = 8'($urandom_range(4));
      rnd.bit_sample = 8'($urandom_range(4));
      rnd.wait_limit = 16'($urandom_range(10));
      rnd.chan_count = 4'($urandom_range(15));
      load_config(rnd);
      run_random(30, 1'b0);
    end

    // Longest response and bit delays on one read; the sensor goes quiet
    // after the first bit so the read stays short.
    gap_pct = 0;
    stall_pct = 0;
    forced_stuck = 1;
    load_config('{20'd0, 16'd1, 8'd1, 8'hFF, 8'hFF, 8'hFF, 16'd40, 4'd2});
    run_random(1, 1'b0);
    forced_stuck = -1;

    drain_results();
    if (tick_out_q.size() != 0)
      report_mismatch("results never delivered", tick_out_q.size(), 0);

    $display("Ran %0d tick requests under %0d register settings with varied idling.",
             requests_sent, settings_loaded);
    $display("Readings finished: %0d, %0d of them with a sensor present.",
             readings_done, readings_present);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
